FILE: rtl/core/v3a_pkg.sv
// Shared constants and types for the three-component vector ALU.
// Holds operation codes, status codes and the control group passed between pipeline parts.
// No dependencies.
`default_nettype none

package v3a_pkg;

    localparam int unsigned WORD_BITS_DEF = 32;
    localparam int unsigned FRAC_BITS_DEF = 16;

    localparam int unsigned CMD_W = 4;

    localparam logic [CMD_W-1:0] CMD_ADD   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SUB   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SCALE = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DIV   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_MAG   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_NORM  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_DOT   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CROSS = 4'd7;
    localparam logic [CMD_W-1:0] CMD_EQUAL = 4'd8;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // Control group that travels alongside the data through every stage.
    typedef struct packed {
        logic             valid;
        logic [CMD_W-1:0] cmd;
    } t_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/v3a_front.sv
// Front end of the vector ALU: input register, shared multipliers, sums and saturation.
// Produces the finished results of the non-dividing operations and the operands for the
// square root and divider. Depends on v3a_pkg.
`default_nettype none

module v3a_front #(
    parameter int unsigned W = v3a_pkg::WORD_BITS_DEF,
    parameter int unsigned F = v3a_pkg::FRAC_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire v3a_pkg::t_ctl       i_ctl,
    input  wire logic signed [W-1:0] i_ax,
    input  wire logic signed [W-1:0] i_ay,
    input  wire logic signed [W-1:0] i_az,
    input  wire logic signed [W-1:0] i_bx,
    input  wire logic signed [W-1:0] i_by,
    input  wire logic signed [W-1:0] i_bz,
    input  wire logic signed [W-1:0] i_scal,
    output v3a_pkg::t_ctl            o_ctl,
    output logic [3*W-1:0]           o_res_v,
    output logic [W-1:0]             o_res_s,
    output logic                     o_ov,
    output logic [2*W-1:0]           o_rad,
    output logic [3*W-1:0]           o_num,
    output logic [2:0]               o_neg,
    output logic [W-1:0]             o_dvs,
    output logic                     o_div0
);
    import v3a_pkg::*;

    localparam int unsigned VW = 2 * W + 2;

    function automatic logic fits_w(input logic [VW-1:0] v);
        return (&v[VW-1:W-1]) | ~(|v[VW-1:W-1]);
    endfunction

    function automatic logic [W-1:0] sat_w(input logic [VW-1:0] v);
        if (fits_w(v)) begin
            return v[W-1:0];
        end
        return v[VW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    // Stage 1: input register.
    t_ctl                r1_ctl;
    logic signed [W-1:0] r1_a [3];
    logic signed [W-1:0] r1_b [3];
    logic signed [W-1:0] r1_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a[0] <= i_ax;
            r1_a[1] <= i_ay;
            r1_a[2] <= i_az;
            r1_b[0] <= i_bx;
            r1_b[1] <= i_by;
            r1_b[2] <= i_bz;
            r1_s    <= i_scal;
        end
    end

    // Stage 2: operand selection and the six multipliers.
    logic signed [W-1:0]   opa [6];
    logic signed [W-1:0]   opb [6];
    logic signed [2*W-1:0] n2_p [6];
    logic signed [W:0]     n2_as [3];
    logic [W-1:0]          n2_num [3];
    logic [2:0]            n2_neg;

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            opa[j] = '0;
            opb[j] = '0;
        end
        case (r1_ctl.cmd)
            CMD_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    opa[i] = r1_a[i];
                    opb[i] = r1_s;
                end
            end
            CMD_MAG, CMD_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    opa[i] = r1_a[i];
                    opb[i] = r1_a[i];
                end
            end
            CMD_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    opa[i] = r1_a[i];
                    opb[i] = r1_b[i];
                end
            end
            CMD_CROSS: begin
                opa[0] = r1_a[1]; opb[0] = r1_b[2];
                opa[1] = r1_a[2]; opb[1] = r1_b[1];
                opa[2] = r1_a[2]; opb[2] = r1_b[0];
                opa[3] = r1_a[0]; opb[3] = r1_b[2];
                opa[4] = r1_a[0]; opb[4] = r1_b[1];
                opa[5] = r1_a[1]; opb[5] = r1_b[0];
            end
            default: begin
            end
        endcase
        for (int j = 0; j < 6; j++) begin
            n2_p[j] = opa[j] * opb[j];
        end
        for (int i = 0; i < 3; i++) begin
            if (r1_ctl.cmd == CMD_SUB) begin
                n2_as[i] = {r1_a[i][W-1], r1_a[i]} - {r1_b[i][W-1], r1_b[i]};
            end else begin
                n2_as[i] = {r1_a[i][W-1], r1_a[i]} + {r1_b[i][W-1], r1_b[i]};
            end
            // The magnitude of the most negative word is exact as an unsigned word.
            n2_num[i] = r1_a[i][W-1] ? (~r1_a[i] + 1'b1) : r1_a[i];
            n2_neg[i] = r1_a[i][W-1] ^ ((r1_ctl.cmd == CMD_DIV) & r1_s[W-1]);
        end
    end

    t_ctl                  r2_ctl;
    logic signed [2*W-1:0] r2_p [6];
    logic signed [W:0]     r2_as [3];
    logic                  r2_eq;
    logic [W-1:0]          r2_num [3];
    logic [2:0]            r2_neg;
    logic [W-1:0]          r2_dvs;
    logic                  r2_div0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (i_en) begin
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_p    <= n2_p;
            r2_as   <= n2_as;
            r2_eq   <= (r1_a[0] == r1_b[0]) && (r1_a[1] == r1_b[1]) && (r1_a[2] == r1_b[2]);
            r2_num  <= n2_num;
            r2_neg  <= n2_neg;
            r2_dvs  <= r1_s[W-1] ? (~r1_s + 1'b1) : r1_s;
            r2_div0 <= (r1_s == '0);
        end
    end

    // Stage 3: exact sums and differences of the products.
    logic [VW-1:0] pe [6];
    logic [VW-1:0] n3_v [3];
    logic [VW-1:0] n3_vs;

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            pe[j] = {{2{r2_p[j][2*W-1]}}, r2_p[j]};
        end
        n3_vs = pe[0] + pe[1] + pe[2];
        for (int i = 0; i < 3; i++) begin
            case (r2_ctl.cmd)
                CMD_ADD, CMD_SUB: n3_v[i] = {{(VW-W-1){r2_as[i][W]}}, r2_as[i]};
                CMD_SCALE:        n3_v[i] = pe[i];
                CMD_CROSS:        n3_v[i] = pe[2*i] - pe[2*i+1];
                default:          n3_v[i] = '0;
            endcase
        end
    end

    t_ctl          r3_ctl;
    logic [VW-1:0] r3_v [3];
    logic [VW-1:0] r3_vs;
    logic          r3_eq;
    logic [W-1:0]  r3_num [3];
    logic [2:0]    r3_neg;
    logic [W-1:0]  r3_dvs;
    logic          r3_div0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else if (i_en) begin
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_v    <= n3_v;
            r3_vs   <= n3_vs;
            r3_eq   <= r2_eq;
            r3_num  <= r2_num;
            r3_neg  <= r2_neg;
            r3_dvs  <= r2_dvs;
            r3_div0 <= r2_div0;
        end
    end

    // Stage 4: fraction alignment and saturation.
    logic signed [VW-1:0] sh [3];
    logic signed [VW-1:0] shs;
    logic [W-1:0]         n4_lane [3];
    logic [2:0]           lane_ov;
    logic                 vec_op;
    logic [3*W-1:0]       n4_res_v;
    logic [W-1:0]         n4_res_s;
    logic                 n4_ov;

    always_comb begin
        vec_op = (r3_ctl.cmd == CMD_ADD) || (r3_ctl.cmd == CMD_SUB) ||
                 (r3_ctl.cmd == CMD_SCALE) || (r3_ctl.cmd == CMD_CROSS);
        for (int i = 0; i < 3; i++) begin
            if ((r3_ctl.cmd == CMD_SCALE) || (r3_ctl.cmd == CMD_CROSS)) begin
                sh[i] = $signed(r3_v[i]) >>> F;
            end else begin
                sh[i] = $signed(r3_v[i]);
            end
            n4_lane[i] = vec_op ? sat_w(sh[i]) : '0;
            lane_ov[i] = ~fits_w(sh[i]);
        end
        shs      = $signed(r3_vs) >>> F;
        n4_res_v = {n4_lane[2], n4_lane[1], n4_lane[0]};
        case (r3_ctl.cmd)
            CMD_DOT:   n4_res_s = sat_w(shs);
            CMD_EQUAL: n4_res_s = {{(W-1){1'b0}}, r3_eq};
            default:   n4_res_s = '0;
        endcase
        if (vec_op) begin
            n4_ov = |lane_ov;
        end else if (r3_ctl.cmd == CMD_DOT) begin
            n4_ov = ~fits_w(shs);
        end else begin
            n4_ov = 1'b0;
        end
    end

    t_ctl r4_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
        end else if (i_en) begin
            r4_ctl <= r3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res_v <= n4_res_v;
            o_res_s <= n4_res_s;
            o_ov    <= n4_ov;
            o_rad   <= r3_vs[2*W-1:0];
            o_num   <= {r3_num[2], r3_num[1], r3_num[0]};
            o_neg   <= r3_neg;
            o_dvs   <= r3_dvs;
            o_div0  <= r3_div0;
        end
    end

    assign o_ctl = r4_ctl;

endmodule

`default_nettype wire

FILE: rtl/core/v3a_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a side band carried along.
// Takes a 2W-bit radicand and gives its W-bit floor root after W stages.
// Depends on v3a_pkg.
`default_nettype none

module v3a_sqrt #(
    parameter int unsigned W    = v3a_pkg::WORD_BITS_DEF,
    parameter int unsigned SB_W = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire v3a_pkg::t_ctl   i_ctl,
    input  wire logic [2*W-1:0]  i_rad,
    input  wire logic [SB_W-1:0] i_sb,
    output v3a_pkg::t_ctl        o_ctl,
    output logic [W-1:0]         o_root,
    output logic [SB_W-1:0]      o_sb
);
    import v3a_pkg::*;

    localparam int unsigned RW = W + 1;

    t_ctl            r_ctl  [W];
    logic [RW-1:0]   r_rem  [W];
    logic [W-1:0]    r_root [W];
    logic [2*W-1:0]  r_x    [W];
    logic [SB_W-1:0] r_sb   [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        t_ctl            p_ctl;
        logic [RW-1:0]   p_rem;
        logic [W-1:0]    p_root;
        logic [2*W-1:0]  p_x;
        logic [SB_W-1:0] p_sb;
        logic [RW+1:0]   rem_t;
        logic [RW+1:0]   trial;
        logic [RW+1:0]   diff;
        logic            ge;

        if (k == 0) begin : g_first
            assign p_ctl  = i_ctl;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_x    = i_rad;
            assign p_sb   = i_sb;
        end else begin : g_next
            assign p_ctl  = r_ctl[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_x    = r_x[k-1];
            assign p_sb   = r_sb[k-1];
        end

        always_comb begin
            rem_t = {p_rem, p_x[2*W-1:2*W-2]};
            trial = {1'b0, p_root, 2'b01};
            diff  = rem_t - trial;
            ge    = (rem_t >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else if (i_en) begin
                r_ctl[k] <= p_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[RW-1:0] : rem_t[RW-1:0];
                r_root[k] <= {p_root[W-2:0], ge};
                r_x[k]    <= {p_x[2*W-3:0], 2'b00};
                r_sb[k]   <= p_sb;
            end
        end
    end

    assign o_ctl  = r_ctl[W-1];
    assign o_root = r_root[W-1];
    assign o_sb   = r_sb[W-1];

endmodule

`default_nettype wire

FILE: rtl/core/v3a_div.sv
// Pipelined restoring divider with three lanes sharing one divisor, one quotient bit per stage.
// Each lane forms (num << F) / dvs over W+F stages; a side band travels alongside.
// Depends on v3a_pkg.
`default_nettype none

module v3a_div #(
    parameter int unsigned W    = v3a_pkg::WORD_BITS_DEF,
    parameter int unsigned F    = v3a_pkg::FRAC_BITS_DEF,
    parameter int unsigned SB_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire v3a_pkg::t_ctl     i_ctl,
    input  wire logic [3*W-1:0]    i_num,
    input  wire logic [W-1:0]      i_dvs,
    input  wire logic [SB_W-1:0]   i_sb,
    output v3a_pkg::t_ctl          o_ctl,
    output logic [3*(W+F)-1:0]     o_quo,
    output logic [SB_W-1:0]        o_sb
);
    import v3a_pkg::*;

    localparam int unsigned QW = W + F;

    t_ctl            r_ctl [QW];
    logic [W-1:0]    r_dvs [QW];
    logic [W-1:0]    r_rem [QW][3];
    logic [QW-1:0]   r_nq  [QW][3];
    logic [SB_W-1:0] r_sb  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        t_ctl            p_ctl;
        logic [W-1:0]    p_dvs;
        logic [W-1:0]    p_rem [3];
        logic [QW-1:0]   p_nq  [3];
        logic [SB_W-1:0] p_sb;
        logic [W:0]      rem_t [3];
        logic [W:0]      diff  [3];
        logic [2:0]      ge;

        if (k == 0) begin : g_first
            assign p_ctl = i_ctl;
            assign p_dvs = i_dvs;
            assign p_sb  = i_sb;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign p_rem[l] = '0;
                assign p_nq[l]  = {i_num[l*W +: W], {F{1'b0}}};
            end
        end else begin : g_next
            assign p_ctl = r_ctl[k-1];
            assign p_dvs = r_dvs[k-1];
            assign p_sb  = r_sb[k-1];
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign p_rem[l] = r_rem[k-1][l];
                assign p_nq[l]  = r_nq[k-1][l];
            end
        end

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                rem_t[l] = {p_rem[l], p_nq[l][QW-1]};
                diff[l]  = rem_t[l] - {1'b0, p_dvs};
                ge[l]    = (rem_t[l] >= {1'b0, p_dvs});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else if (i_en) begin
                r_ctl[k] <= p_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dvs[k] <= p_dvs;
                r_sb[k]  <= p_sb;
                for (int l = 0; l < 3; l++) begin
                    r_rem[k][l] <= ge[l] ? diff[l][W-1:0] : rem_t[l][W-1:0];
                    r_nq[k][l]  <= {p_nq[l][QW-2:0], ge[l]};
                end
            end
        end
    end

    assign o_ctl = r_ctl[QW-1];
    assign o_sb  = r_sb[QW-1];
    assign o_quo = {r_nq[QW-1][2], r_nq[QW-1][1], r_nq[QW-1][0]};

endmodule

`default_nettype wire

FILE: rtl/core/vector3_alu_unit.sv
// Top level of the three-component vector ALU in signed fixed point.
// Instantiates v3a_front, v3a_sqrt and v3a_div and holds the result stage and output register.
// Depends on v3a_pkg.
`default_nettype none

// The unit takes one item per clock cycle while o_stall is low and returns exactly one result
// item for each, in order. Every item, whatever its operation, runs the same fixed pipeline:
// four front stages (input register, multipliers, exact sums, alignment and saturation),
// WORD_BITS stages of the square root, WORD_BITS + FRAC_BITS stages of the three-lane
// divider and the output register; the default format is Q16.16. The sustained rate is one
// item per cycle unless the receiver stalls a result; the bit-per-stage square root and
// divider set the depth. When the output register holds a result that the receiver stalls,
// the whole pipeline holds and o_stall is raised; otherwise an item is taken in every cycle,
// even while the output register is being emptied. The unit has no state beyond the pipeline,
// and reset merely clears the valid bits.

module vector3_alu_unit #(
    parameter int unsigned WORD_BITS = v3a_pkg::WORD_BITS_DEF,
    parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [v3a_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic signed [WORD_BITS-1:0] i_ax,
    input  wire logic signed [WORD_BITS-1:0] i_ay,
    input  wire logic signed [WORD_BITS-1:0] i_az,
    input  wire logic signed [WORD_BITS-1:0] i_bx,
    input  wire logic signed [WORD_BITS-1:0] i_by,
    input  wire logic signed [WORD_BITS-1:0] i_bz,
    input  wire logic signed [WORD_BITS-1:0] i_scal,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic signed [WORD_BITS-1:0]      o_rx,
    output logic signed [WORD_BITS-1:0]      o_ry,
    output logic signed [WORD_BITS-1:0]      o_rz,
    output logic signed [WORD_BITS-1:0]      o_scalar_out,
    output logic [1:0]                       o_status
);
    import v3a_pkg::*;

    localparam int unsigned W    = WORD_BITS;
    localparam int unsigned F    = FRAC_BITS;
    localparam int unsigned QW   = W + F;
    // Side band into the square root: front results plus the divider operands.
    localparam int unsigned SB1_W = 8 * W + 5;
    // Side band into the divider: front results, signs, zero-divisor flag and the root.
    localparam int unsigned SB2_W = 5 * W + 5;

    // The whole pipeline moves together; it only holds when a finished result is refused.
    logic adv;
    logic r_out_vld;

    assign adv     = !r_out_vld || !i_stall;
    assign o_stall = !adv;

    t_ctl in_ctl;
    assign in_ctl.valid = i_valid;
    assign in_ctl.cmd   = i_cmd;

    // Front end: products, sums and every result that needs no square root or division.
    t_ctl           f_ctl;
    logic [3*W-1:0] f_res_v;
    logic [W-1:0]   f_res_s;
    logic           f_ov;
    logic [2*W-1:0] f_rad;
    logic [3*W-1:0] f_num;
    logic [2:0]     f_neg;
    logic [W-1:0]   f_dvs;
    logic           f_div0;

    v3a_front #(
        .W (W),
        .F (F)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_ctl   (in_ctl),
        .i_ax    (i_ax),
        .i_ay    (i_ay),
        .i_az    (i_az),
        .i_bx    (i_bx),
        .i_by    (i_by),
        .i_bz    (i_bz),
        .i_scal  (i_scal),
        .o_ctl   (f_ctl),
        .o_res_v (f_res_v),
        .o_res_s (f_res_s),
        .o_ov    (f_ov),
        .o_rad   (f_rad),
        .o_num   (f_num),
        .o_neg   (f_neg),
        .o_dvs   (f_dvs),
        .o_div0  (f_div0)
    );

    // Square root of the sum of squares, used by magnitude and normalise.
    t_ctl             s_ctl;
    logic [W-1:0]     s_root;
    logic [SB1_W-1:0] s_sb;
    logic [3*W-1:0]   s_res_v;
    logic [W-1:0]     s_res_s;
    logic             s_ov;
    logic [3*W-1:0]   s_num;
    logic [2:0]       s_neg;
    logic [W-1:0]     s_dvs;
    logic             s_div0;

    v3a_sqrt #(
        .W    (W),
        .SB_W (SB1_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_ctl   (f_ctl),
        .i_rad   (f_rad),
        .i_sb    ({f_res_v, f_res_s, f_ov, f_num, f_neg, f_dvs, f_div0}),
        .o_ctl   (s_ctl),
        .o_root  (s_root),
        .o_sb    (s_sb)
    );

    assign {s_res_v, s_res_s, s_ov, s_num, s_neg, s_dvs, s_div0} = s_sb;

    // The divider divides by the scalar's magnitude for divide and by the root for normalise.
    logic [W-1:0]     dvs_sel;
    t_ctl             d_ctl;
    logic [3*QW-1:0]  d_quo;
    logic [SB2_W-1:0] d_sb;
    logic [3*W-1:0]   d_res_v;
    logic [W-1:0]     d_res_s;
    logic             d_ov;
    logic [2:0]       d_neg;
    logic             d_div0;
    logic [W-1:0]     d_root;

    assign dvs_sel = (s_ctl.cmd == CMD_NORM) ? s_root : s_dvs;

    v3a_div #(
        .W    (W),
        .F    (F),
        .SB_W (SB2_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_ctl   (s_ctl),
        .i_num   (s_num),
        .i_dvs   (dvs_sel),
        .i_sb    ({s_res_v, s_res_s, s_ov, s_neg, s_div0, s_root}),
        .o_ctl   (d_ctl),
        .o_quo   (d_quo),
        .o_sb    (d_sb)
    );

    assign {d_res_v, d_res_s, d_ov, d_neg, d_div0, d_root} = d_sb;

    // Result stage: signs and saturation of the quotients, and the final selection.
    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    logic [QW-1:0] q     [3];
    logic [W-1:0]  q_val [3];
    logic [2:0]    q_ov;
    logic          q_fit;
    logic [W-1:0]  n_rx;
    logic [W-1:0]  n_ry;
    logic [W-1:0]  n_rz;
    logic [W-1:0]  n_sc;
    logic [1:0]    n_st;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            q[l] = d_quo[l*QW +: QW];
            if (d_neg[l]) begin
                // A negative result may reach one step further, down to the word minimum.
                q_fit    = ~(|q[l][QW-1:W]) & (~q[l][W-1] | ~(|q[l][W-2:0]));
                q_val[l] = q_fit ? (~q[l][W-1:0] + 1'b1) : WMIN;
            end else begin
                q_fit    = ~(|q[l][QW-1:W-1]);
                q_val[l] = q_fit ? q[l][W-1:0] : WMAX;
            end
            q_ov[l] = ~q_fit;
        end

        n_rx = '0;
        n_ry = '0;
        n_rz = '0;
        n_sc = '0;
        n_st = ST_OK;
        case (d_ctl.cmd)
            CMD_DIV: begin
                if (d_div0) begin
                    n_st = ST_DIV0;
                end else begin
                    n_rx = q_val[0];
                    n_ry = q_val[1];
                    n_rz = q_val[2];
                    n_st = (|q_ov) ? ST_SAT : ST_OK;
                end
            end
            CMD_NORM: begin
                // Normalising the zero vector gives the zero vector without a fault.
                if (d_root != '0) begin
                    n_rx = q_val[0];
                    n_ry = q_val[1];
                    n_rz = q_val[2];
                    n_st = (|q_ov) ? ST_SAT : ST_OK;
                end
            end
            CMD_MAG: begin
                n_sc = d_root[W-1] ? WMAX : d_root;
                n_st = d_root[W-1] ? ST_SAT : ST_OK;
            end
            default: begin
                n_rx = d_res_v[0 +: W];
                n_ry = d_res_v[W +: W];
                n_rz = d_res_v[2*W +: W];
                n_sc = d_res_s;
                n_st = d_ov ? ST_SAT : ST_OK;
            end
        endcase
    end

    // Output register.
    logic signed [W-1:0] r_rx;
    logic signed [W-1:0] r_ry;
    logic signed [W-1:0] r_rz;
    logic signed [W-1:0] r_sc;
    logic [1:0]          r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= d_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rx <= n_rx;
            r_ry <= n_ry;
            r_rz <= n_rz;
            r_sc <= n_sc;
            r_st <= n_st;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_rx         = r_rx;
    assign o_ry         = r_ry;
    assign o_rz         = r_rz;
    assign o_scalar_out = r_sc;
    assign o_status     = r_st;

    // A division by zero always comes back as an all-zero result.
    a_div0_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_DIV0)) |->
        ((o_rx == '0) && (o_ry == '0) && (o_rz == '0) && (o_scalar_out == '0)))
        else $error("divide-by-zero item carries a non-zero result");

    // Input back-pressure only ever comes from a refused result in the output register.
    a_stall_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a refused result");

    // An operation yields either a vector or a scalar, never both.
    a_scalar_or_vector : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_scalar_out != '0)) |->
        ((o_rx == '0) && (o_ry == '0) && (o_rz == '0)))
        else $error("scalar and vector results both non-zero");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the three-component vector ALU (vector3_alu_unit).
// A built-in fixed-point predictor produces each expected result, and a checker compares it
// with the item that the unit returns. Depends on v3a_pkg and the RTL.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import v3a_pkg::*;

    localparam int LATENCY    = 85;
    localparam int WATCH_MAX  = 5000;
    localparam int REPORT_MAX = 10;

    localparam logic signed [127:0] WORD_MAX = 128'sh7fff_ffff;
    localparam logic signed [127:0] WORD_MIN = -128'sh8000_0000;

    // One operation as it is offered to the unit.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [31:0]      s;
    } t_vec_op;

    // One result as the unit returns it.
    typedef struct packed {
        logic [2:0][31:0] r;
        logic [31:0]      sc;
        logic [1:0]       st;
    } t_vec_res;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [CMD_W-1:0] i_cmd;
    logic [31:0]      i_ax, i_ay, i_az, i_bx, i_by, i_bz, i_scal;
    logic             o_valid;
    logic             i_stall;
    logic [31:0]      o_rx, o_ry, o_rz, o_scalar_out;
    logic [1:0]       o_status;

    t_vec_res awaited_q[$];
    int       mismatches;
    int       results_seen;
    int       items_sent;
    int       idle_stuck;
    bit       quiet;      // when set, neither side idles at random
    bit       hold_req;   // asks the receiver for a long hold-off
    int       hold_left;
    int       op_count[16];

    vector3_alu_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_ax         (i_ax),
        .i_ay         (i_ay),
        .i_az         (i_az),
        .i_bx         (i_bx),
        .i_by         (i_by),
        .i_bz         (i_bz),
        .i_scal       (i_scal),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_rx         (o_rx),
        .o_ry         (o_ry),
        .o_rz         (o_rz),
        .o_scalar_out (o_scalar_out),
        .o_status     (o_status)
    );

    // The clock runs at a 4 ns period.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Clamps an exact value into the 32-bit word and notes any overflow.
    function automatic logic [31:0] clamp_word(input logic signed [127:0] v, inout bit ovf);
        if (v > WORD_MAX) begin
            ovf = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < WORD_MIN) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Floor square root of an unsigned 128-bit value, one bit at a time.
    function automatic logic [63:0] root_floor(input logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            c  = r | (64'd1 << i);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= v)
                r = c;
        end
        return r;
    endfunction

    // Scaled quotient (|n| << 16) / d, truncated, with the sign given.
    function automatic logic signed [127:0] scaled_quot(input logic [127:0] n_mag,
                                                        input logic [127:0] d, input bit neg);
        logic [127:0] q;
        q = (n_mag << 16) / d;
        return neg ? -$signed(q) : $signed(q);
    endfunction

    // Works out the result that the unit must return for one operation.
    function automatic t_vec_res alu_predict(input t_vec_op op);
        t_vec_res               res;
        bit                     ovf;
        logic signed [127:0]    ea[3];
        logic signed [127:0]    eb[3];
        logic signed [127:0]    es;
        logic signed [127:0]    acc;
        logic [127:0]           amag[3];
        logic [127:0]           smag;
        logic [63:0]            m;
        int                     j, k;
        res = '0;
        ovf = 1'b0;
        for (int i = 0; i < 3; i++) begin
            ea[i]   = $signed(op.a[i]);
            eb[i]   = $signed(op.b[i]);
            amag[i] = ea[i] < 0 ? -ea[i] : ea[i];
        end
        es   = $signed(op.s);
        smag = es < 0 ? -es : es;
        case (op.cmd)
            CMD_ADD, CMD_SUB: begin
                for (int i = 0; i < 3; i++)
                    res.r[i] = clamp_word(op.cmd == CMD_ADD ? ea[i] + eb[i]
                                                            : ea[i] - eb[i], ovf);
            end
            CMD_SCALE: begin
                for (int i = 0; i < 3; i++)
                    res.r[i] = clamp_word((ea[i] * es) >>> 16, ovf);
            end
            CMD_DIV: begin
                if (es == 0) begin
                    res.st = ST_DIV0;
                end else begin
                    for (int i = 0; i < 3; i++)
                        res.r[i] = clamp_word(scaled_quot(amag[i], smag,
                                              (ea[i] < 0) != (es < 0)), ovf);
                end
            end
            CMD_MAG, CMD_NORM: begin
                acc = ea[0] * ea[0] + ea[1] * ea[1] + ea[2] * ea[2];
                m   = root_floor(acc);
                if (op.cmd == CMD_MAG) begin
                    res.sc = clamp_word($signed({64'd0, m}), ovf);
                end else if (m != 0) begin
                    for (int i = 0; i < 3; i++)
                        res.r[i] = clamp_word(scaled_quot(amag[i], {64'd0, m}, ea[i] < 0), ovf);
                end
            end
            CMD_DOT: begin
                acc    = ea[0] * eb[0] + ea[1] * eb[1] + ea[2] * eb[2];
                res.sc = clamp_word(acc >>> 16, ovf);
            end
            CMD_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    res.r[i] = clamp_word((ea[j] * eb[k] - ea[k] * eb[j]) >>> 16, ovf);
                end
            end
            CMD_EQUAL: begin
                res.sc = (op.a == op.b) ? 32'd1 : 32'd0;
            end
            default: ;
        endcase
        if (ovf)
            res.st = ST_SAT;
        return res;
    endfunction

    // Offers one item, idling now and then, and records its expected result once taken.
    task automatic send_item(input t_vec_op op);
        while (!quiet && $urandom_range(0, 99) < 9) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= op.cmd;
        i_ax    <= op.a[0];
        i_ay    <= op.a[1];
        i_az    <= op.a[2];
        i_bx    <= op.b[0];
        i_by    <= op.b[1];
        i_bz    <= op.b[2];
        i_scal  <= op.s;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        awaited_q.push_back(alu_predict(op));
        items_sent++;
        op_count[op.cmd]++;
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_q.size() != 0)
            @(posedge i_clk);
    endtask

    // A random word biased towards the extremes and towards modest magnitudes.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hffff_ffff;
                    default: return 32'h0001_0000;
                endcase
            end
            1, 2, 3: return $unsigned($signed(32'($urandom_range(0, 16)) - 8) <<< 16)
                            ^ 32'($urandom_range(0, 65535));
            4, 5: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
            default: return $urandom();
        endcase
    endfunction

    function automatic t_vec_op pick_op();
        t_vec_op op;
        op.cmd = ($urandom_range(0, 19) == 0) ? CMD_W'($urandom_range(9, 15))
                                              : CMD_W'($urandom_range(0, 8));
        for (int i = 0; i < 3; i++) begin
            op.a[i] = pick_word();
            op.b[i] = pick_word();
        end
        op.s = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_word();
        // Equality is rarely met by chance, so copy a into b now and then.
        if ($urandom_range(0, 3) == 0)
            op.b = op.a;
        return op;
    endfunction

    function automatic t_vec_op make_op(input logic [CMD_W-1:0] cmd, input logic [31:0] ax,
                                        input logic [31:0] ay, input logic [31:0] az,
                                        input logic [31:0] bx, input logic [31:0] by,
                                        input logic [31:0] bz, input logic [31:0] s);
        t_vec_op op;
        op.cmd = cmd;
        op.a   = {az, ay, ax};
        op.b   = {bz, by, bx};
        op.s   = s;
        return op;
    endfunction

    // Receiver side: random stalls, a quiet stretch, and a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left <= 300;
            i_stall   <= 1'b1;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            hold_left <= 0;
            i_stall   <= !quiet && ($urandom_range(0, 99) < 9);
        end
    end

    // Checks each result that the unit hands over against the oldest expectation.
    always @(posedge i_clk) begin
        t_vec_res got;
        t_vec_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_rz, o_ry, o_rx, o_scalar_out, o_status};
            results_seen++;
            if (awaited_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"ERROR: result with nothing expected: ",
                              "rx=%h ry=%h rz=%h sc=%h st=%0d"},
                             o_rx, o_ry, o_rz, o_scalar_out, o_status);
            end else begin
                want = awaited_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"ERROR: result %0d: expected rx=%h ry=%h rz=%h sc=%h ",
                                  "st=%0d, got rx=%h ry=%h rz=%h sc=%h st=%0d"},
                                 results_seen, want.r[0], want.r[1], want.r[2], want.sc,
                                 want.st, o_rx, o_ry, o_rz, o_scalar_out, o_status);
                end
            end
        end
    end

    // Watchdog: a run in which nothing moves for too long is a failure.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_stuck <= 0;
        end else if (idle_stuck >= WATCH_MAX) begin
            $display("vector3_alu_unit test failed");
            $finish;
        end else begin
            idle_stuck <= idle_stuck + 1;
        end
    end

    // Extremes of the fields, every operation, and each special case by name.
    task automatic test_directed();
        send_item(make_op(CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
                          32'h0000_0001, 32'hffff_ffff, 32'h0002_8000, 32'h0));
        send_item(make_op(CMD_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
                          32'h0000_0001, 32'hffff_ffff, 32'h0, 32'h0));
        send_item(make_op(CMD_SCALE, 32'h0003_0000, 32'hfffe_8000, 32'h7fff_ffff,
                          32'h0, 32'h0, 32'h0, 32'h0002_0000));
        send_item(make_op(CMD_SCALE, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff,
                          32'h0, 32'h0, 32'h0, 32'h8000_0000));
        send_item(make_op(CMD_DIV, 32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff,
                          32'h0, 32'h0, 32'h0, 32'h0003_0000));
        // Division by zero gives a zero vector and its own status.
        send_item(make_op(CMD_DIV, 32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff,
                          32'h0, 32'h0, 32'h0, 32'h0));
        // Dividing by a tiny scalar overflows and saturates.
        send_item(make_op(CMD_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
                          32'h0, 32'h0, 32'h0, 32'h0000_0001));
        send_item(make_op(CMD_DIV, 32'h8000_0000, 32'h0, 32'h0,
                          32'h0, 32'h0, 32'h0, 32'hffff_ffff));
        send_item(make_op(CMD_MAG, 32'h0003_0000, 32'h0004_0000, 32'h0,
                          32'h0, 32'h0, 32'h0, 32'h0));
        send_item(make_op(CMD_MAG, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h0, 32'h0, 32'h0, 32'h0));
        send_item(make_op(CMD_NORM, 32'h0003_0000, 32'hfffc_0000, 32'h0,
                          32'h0, 32'h0, 32'h0, 32'h0));
        // A zero vector normalises to a zero vector with a clean status.
        send_item(make_op(CMD_NORM, 32'h0, 32'h0, 32'h0,
                          32'h0, 32'h0, 32'h0, 32'h0));
        send_item(make_op(CMD_NORM, 32'h0000_0001, 32'h0, 32'h0,
                          32'h0, 32'h0, 32'h0, 32'h0));
        send_item(make_op(CMD_NORM, 32'h8000_0000, 32'h0, 32'h0,
                          32'h0, 32'h0, 32'h0, 32'h0));
        send_item(make_op(CMD_DOT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                          32'h0004_0000, 32'hfffb_0000, 32'h0006_0000, 32'h0));
        send_item(make_op(CMD_DOT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0));
        send_item(make_op(CMD_CROSS, 32'h0001_0000, 32'h0, 32'h0,
                          32'h0, 32'h0001_0000, 32'h0, 32'h0));
        send_item(make_op(CMD_CROSS, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                          32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0));
        send_item(make_op(CMD_EQUAL, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
                          32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0));
        send_item(make_op(CMD_EQUAL, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
                          32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'h0));
        // Unknown operation codes return all zeros.
        send_item(make_op(CMD_W'(9), 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                          32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        send_item(make_op(CMD_W'(15), 32'h7fff_ffff, 32'h0, 32'h8000_0000,
                          32'h1, 32'h2, 32'h3, 32'h4));
        wait_drained();
    endtask

    // The bulk of the run, with a stretch in the middle where nobody idles.
    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            quiet = (n >= count / 3) && (n < count / 3 + 200);
            send_item(pick_op());
        end
        quiet = 1'b0;
    endtask

    // The receiver holds off for a long time while items keep coming, so the unit fills up
    // and stalls its input; afterwards the sender waits for everything to come back.
    task automatic test_back_pressure();
        hold_req = 1'b1;
        for (int n = 0; n < 150; n++)
            send_item(pick_op());
        wait_drained();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_stall    = 1'b0;
        i_cmd      = '0;
        {i_ax, i_ay, i_az, i_bx, i_by, i_bz, i_scal} = '0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        idle_stuck = 0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        foreach (op_count[i])
            op_count[i] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(550);
        test_back_pressure();
        test_random(550);

        wait_drained();
        repeat (LATENCY + 20) @(posedge i_clk);

        $display({"Covered %0d items over every operation and unknown codes ",
                  "(add %0d, div %0d, norm %0d, cross %0d),"},
                 items_sent, op_count[CMD_ADD], op_count[CMD_DIV], op_count[CMD_NORM],
                 op_count[CMD_CROSS]);
        $display("with random idling, a long receiver hold-off and a full drain; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && awaited_q.size() == 0) begin
            $display("vector3_alu_unit test passed");
        end else begin
            $display("vector3_alu_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
